// ----- rtl/wsd_pkg.sv -----
// wsd_pkg: shared types and constants for the WebSocket frame deframer.
// Used by wsd_parser, wsd_queue and websocket_frame_deframer.
package wsd_pkg;

	localparam int MAX_MESSAGE_BYTES = 4096;
	localparam int PREFIX_BYTES      = 2;
	localparam int QUEUE_DEPTH       = 4;
	localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW          = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	localparam logic [1:0] KIND_MSG   = 2'd0;
	localparam logic [1:0] KIND_PING  = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;
	localparam logic [1:0] KIND_EMPTY = 2'd3;

	localparam logic [1:0] CC_NORMAL = 2'd0;
	localparam logic [1:0] CC_PROTO  = 2'd1;
	localparam logic [1:0] CC_UNSUP  = 2'd2;
	localparam logic [1:0] CC_BIG    = 2'd3;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [15:0] PING_MAX = 16'd125;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [1:0] code;
		logic       flast;
		logic       mend;
		logic       pok;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	function automatic logic prefix_match(input logic [16:0] total, input logic [15:0] pv);
		logic [16:0] exp;
		exp = total - 17'(PREFIX_BYTES);
		return (total >= 17'(PREFIX_BYTES)) && ({1'b0, pv} == exp);
	endfunction

endpackage

// ----- rtl/wsd_parser.sv -----
// wsd_parser: front end, parses header, length and mask, unmasks payload.
// Emits at most one result per accepted byte. Depends on wsd_pkg.
module wsd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             beat_en,
	input  logic [7:0]       data_byte,
	output logic             res_valid,
	output wsd_pkg::result_t res
);
	import wsd_pkg::*;

	localparam logic [3:0] PH_HDR0    = 4'd0;
	localparam logic [3:0] PH_HDR1    = 4'd1;
	localparam logic [3:0] PH_EXT0    = 4'd2;
	localparam logic [3:0] PH_EXT1    = 4'd3;
	localparam logic [3:0] PH_MASK0   = 4'd4;
	localparam logic [3:0] PH_MASK1   = 4'd5;
	localparam logic [3:0] PH_MASK2   = 4'd6;
	localparam logic [3:0] PH_MASK3   = 4'd7;
	localparam logic [3:0] PH_PAYLOAD = 4'd8;

	logic [3:0]  phase_q, phase_d;
	logic        fin_q, fin_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        rsv_q, rsv_d;
	logic [15:0] plen_q, plen_d;
	logic [15:0] pidx_q, pidx_d;
	logic [31:0] key_q, key_d;
	logic [15:0] mtotal_q, mtotal_d;
	logic [15:0] prefix_q, prefix_d;
	logic        halted_q, halted_d;

	logic [15:0] len_val;
	logic [16:0] len_sum;
	logic        is_msg;
	logic [7:0]  key_byte;
	logic [7:0]  data_x;
	logic [16:0] pidx_inc;
	logic        last;
	logic [16:0] pos;
	logic [16:0] total;

	assign is_msg   = (opcode_q == OP_BIN) || (opcode_q == OP_CONT);
	assign len_val  = (phase_q == PH_EXT1) ? {plen_q[15:8], data_byte} : {9'd0, data_byte[6:0]};
	assign len_sum  = {1'b0, mtotal_q} + {1'b0, len_val};
	assign key_byte = key_q[8 * (3 - pidx_q[1:0]) +: 8];
	assign data_x   = data_byte ^ key_byte;
	assign pidx_inc = {1'b0, pidx_q} + 17'd1;
	assign last     = pidx_inc >= {1'b0, plen_q};
	assign pos      = {1'b0, mtotal_q} + {1'b0, pidx_q};
	assign total    = {1'b0, mtotal_q} + {1'b0, plen_q};

	always_comb begin
		phase_d   = phase_q;
		fin_d     = fin_q;
		opcode_d  = opcode_q;
		rsv_d     = rsv_q;
		plen_d    = plen_q;
		pidx_d    = pidx_q;
		key_d     = key_q;
		mtotal_d  = mtotal_q;
		prefix_d  = prefix_q;
		halted_d  = halted_q;
		res_valid = 1'b0;
		res       = '0;
		if (!halted_q) begin
			unique case (phase_q)
				PH_HDR0: begin
					fin_d    = data_byte[7];
					opcode_d = data_byte[3:0];
					rsv_d    = |data_byte[6:4];
					phase_d  = PH_HDR1;
				end
				PH_HDR1, PH_EXT1: begin
					if (phase_q == PH_HDR1 && (!data_byte[7] || rsv_q)) begin
						halted_d = 1'b1;
						res_valid = 1'b1;
						res.kind = KIND_CLOSE;
						res.code = CC_PROTO;
					end else if (phase_q == PH_HDR1 && data_byte[6:0] == LEN_EXT64) begin
						halted_d = 1'b1;
						res_valid = 1'b1;
						res.kind = KIND_CLOSE;
						res.code = CC_BIG;
					end else if (phase_q == PH_HDR1 && data_byte[6:0] == LEN_EXT16) begin
						rsv_d   = 1'b0;
						phase_d = PH_EXT0;
					end else begin
						rsv_d   = 1'b0;
						plen_d  = len_val;
						phase_d = PH_MASK0;
						priority if (opcode_q == OP_TEXT) begin
							halted_d = 1'b1;
							res_valid = 1'b1;
							res.kind = KIND_CLOSE;
							res.code = CC_UNSUP;
						end else if (opcode_q == OP_CLOSE) begin
							halted_d = 1'b1;
							res_valid = 1'b1;
							res.kind = KIND_CLOSE;
							res.code = CC_NORMAL;
						end else if (opcode_q == OP_PING) begin
							if (len_val > PING_MAX) begin
								halted_d = 1'b1;
								res_valid = 1'b1;
								res.kind = KIND_CLOSE;
								res.code = CC_BIG;
							end
						end else if (opcode_q == OP_PONG) begin
						end else if (is_msg) begin
							if (len_sum > 17'(MAX_MESSAGE_BYTES)) begin
								halted_d = 1'b1;
								res_valid = 1'b1;
								res.kind = KIND_CLOSE;
								res.code = CC_BIG;
							end
						end else begin
							halted_d = 1'b1;
							res_valid = 1'b1;
							res.kind = KIND_CLOSE;
							res.code = CC_PROTO;
						end
					end
				end
				PH_EXT0: begin
					plen_d  = {data_byte, 8'd0};
					phase_d = PH_EXT1;
				end
				PH_MASK0, PH_MASK1, PH_MASK2: begin
					key_d   = {key_q[23:0], data_byte};
					phase_d = phase_q + 4'd1;
				end
				PH_MASK3: begin
					key_d  = {key_q[23:0], data_byte};
					pidx_d = '0;
					if (plen_q != '0) begin
						phase_d = PH_PAYLOAD;
					end else begin
						phase_d = PH_HDR0;
						if (is_msg && fin_q) begin
							mtotal_d  = '0;
							res_valid = 1'b1;
							res.kind  = KIND_EMPTY;
							res.mend  = 1'b1;
							res.pok   = prefix_match({1'b0, mtotal_q}, prefix_q);
						end
					end
				end
				PH_PAYLOAD: begin
					if (is_msg) begin
						if (pos == 17'd0)
							prefix_d = {prefix_q[15:8], data_x};
						else if (pos == 17'd1)
							prefix_d = {data_x, prefix_q[7:0]};
					end
					pidx_d   = pidx_inc[15:0];
					res.data = data_x;
					if (is_msg) begin
						res_valid = 1'b1;
						res.kind  = KIND_MSG;
					end else if (opcode_q == OP_PING) begin
						res_valid = 1'b1;
						res.kind  = KIND_PING;
					end
					if (last) begin
						phase_d   = PH_HDR0;
						pidx_d    = '0;
						res.flast = 1'b1;
						if (is_msg) begin
							if (fin_q) begin
								mtotal_d = '0;
								res.mend = 1'b1;
								res.pok  = prefix_match(total, prefix_d);
							end else begin
								mtotal_d = total[15:0];
							end
						end
					end
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			fin_q    <= 1'b0;
			opcode_q <= '0;
			rsv_q    <= 1'b0;
			plen_q   <= '0;
			pidx_q   <= '0;
			key_q    <= '0;
			mtotal_q <= '0;
			prefix_q <= '0;
			halted_q <= 1'b0;
		end else if (beat_en) begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			opcode_q <= opcode_d;
			rsv_q    <= rsv_d;
			plen_q   <= plen_d;
			pidx_q   <= pidx_d;
			key_q    <= key_d;
			mtotal_q <= mtotal_d;
			prefix_q <= prefix_d;
			halted_q <= halted_d;
		end
	end

endmodule

// ----- rtl/wsd_queue.sv -----
// wsd_queue: short result queue between parser and output; head drives the port.
// Depends on wsd_pkg.
module wsd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  wsd_pkg::result_t     push_res,
	input  logic                 pop,
	output wsd_pkg::result_t     head,
	output wsd_pkg::queue_stat_t stat
);
	import wsd_pkg::*;

	result_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wptr_q;
	logic [QUEUE_AW-1:0]   rptr_q;
	logic [QUEUE_CW-1:0]   count_q;

	assign stat.full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + QUEUE_AW'(1);
			if (pop)
				rptr_q <= rptr_q + QUEUE_AW'(1);
			if (push && !pop)
				count_q <= count_q + QUEUE_CW'(1);
			else if (pop && !push)
				count_q <= count_q - QUEUE_CW'(1);
		end
	end

endmodule

// ----- rtl/websocket_frame_deframer.sv -----
// websocket_frame_deframer: top level, parser front end feeding a result queue.
// Depends on wsd_pkg, wsd_parser, wsd_queue.
//
//   channel | valid        | stall        | payload
//   input   | data_valid   | data_stall   | data_byte
//   output  | result_valid | result_stall | out_kind out_byte close_code
//           |              |              | frame_last message_end prefix_ok
//
// One byte per cycle while data_stall is low; each result is registered into the
// queue and reaches the output once the entries ahead of it have been taken.
// data_stall rises only when the four-entry result queue is full.
// Reset clears the parser state and empties the queue; after a close the
// block keeps taking bytes and gives no result until reset.
module websocket_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic [1:0] close_code,
	output logic       frame_last,
	output logic       message_end,
	output logic       prefix_ok
);
	import wsd_pkg::*;

	logic        beat_in;
	logic        beat_out;
	logic        res_valid;
	result_t     res;
	result_t     head;
	queue_stat_t stat;

	assign data_stall   = stat.full;
	assign result_valid = !stat.empty;
	assign beat_in      = data_valid && !data_stall;
	assign beat_out     = result_valid && !result_stall;

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_en   (beat_in),
		.data_byte (data_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (beat_in && res_valid),
		.push_res (res),
		.pop      (beat_out),
		.head     (head),
		.stat     (stat)
	);

	assign out_kind    = head.kind;
	assign out_byte    = head.data;
	assign close_code  = head.code;
	assign frame_last  = head.flast;
	assign message_end = head.mend;
	assign prefix_ok   = head.pok;

	// close is the last result ever queued
	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		beat_out && out_kind == KIND_CLOSE |=> !result_valid)
		else $error("result after close");

	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> result_valid)
		else $error("stall with empty queue");

	a_close_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && out_kind == KIND_CLOSE |-> !frame_last && !message_end)
		else $error("close carries frame flags");

	a_pok_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && prefix_ok |-> message_end)
		else $error("prefix_ok outside message end");

endmodule

// ----- tb/sv/websocket_frame_deframer_checker.sv -----
// Scoreboard for websocket_frame_deframer: watches both channels, runs a
// byte-level model of the frame parser and compares every result beat.
// Depends on wsd_pkg for the opcode, kind and close code constants.
`timescale 1ns / 100ps

module websocket_frame_deframer_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	input  logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       result_valid,
	input  logic       result_stall,
	input  logic [1:0] out_kind,
	input  logic [7:0] out_byte,
	input  logic [1:0] close_code,
	input  logic       frame_last,
	input  logic       message_end,
	input  logic       prefix_ok,
	output int         fail_count,
	output int         pending,
	output int         results_checked
);
	import wsd_pkg::*;

	typedef enum logic [3:0] {
		ST_HEAD0, ST_HEAD1, ST_EXT0, ST_EXT1,
		ST_KEY0, ST_KEY1, ST_KEY2, ST_KEY3, ST_DATA
	} parse_st_t;

	parse_st_t   st;
	logic        closed;
	logic        fin;
	logic [2:0]  rsv;
	logic [3:0]  opcode;
	logic [15:0] plen;
	logic [15:0] pidx;
	logic [31:0] key;
	logic [15:0] msg_total;
	logic [15:0] prefix_val;
	result_t     expected_results[$];

	task automatic expect_result(input logic [1:0] kind, input logic [7:0] data,
		input logic [1:0] code, input logic flast, input logic mend, input logic pok);
		result_t r;
		r.kind  = kind;
		r.data  = data;
		r.code  = code;
		r.flast = flast;
		r.mend  = mend;
		r.pok   = pok;
		expected_results.push_back(r);
	endtask

	task automatic close_with(input logic [1:0] code);
		closed = 1'b1;
		expect_result(KIND_CLOSE, 8'h00, code, 1'b0, 1'b0, 1'b0);
	endtask

	function automatic logic prefix_good(input int total);
		return (total >= PREFIX_BYTES) && (int'(prefix_val) == total - PREFIX_BYTES);
	endfunction

	task automatic length_known();
		case (opcode)
			OP_TEXT: close_with(CC_UNSUP);
			OP_CLOSE: close_with(CC_NORMAL);
			OP_PING: begin
				if (plen > PING_MAX)
					close_with(CC_BIG);
				else
					st = ST_KEY0;
			end
			OP_PONG: st = ST_KEY0;
			OP_CONT, OP_BIN: begin
				if (int'(msg_total) + int'(plen) > MAX_MESSAGE_BYTES)
					close_with(CC_BIG);
				else
					st = ST_KEY0;
			end
			default: close_with(CC_PROTO);
		endcase
	endtask

	task automatic predict_byte(input logic [7:0] b);
		logic [7:0] d;
		logic       lastb;
		logic       is_msg;
		int         pos;
		int         tot;
		if (closed)
			return;
		is_msg = (opcode == OP_BIN) || (opcode == OP_CONT);
		case (st)
			ST_HEAD0: begin
				fin    = b[7];
				rsv    = b[6:4];
				opcode = b[3:0];
				st     = ST_HEAD1;
			end
			ST_HEAD1: begin
				if (!b[7] || rsv != 3'd0)
					close_with(CC_PROTO);
				else if (b[6:0] == LEN_EXT64)
					close_with(CC_BIG);
				else if (b[6:0] == LEN_EXT16)
					st = ST_EXT0;
				else begin
					plen = {9'd0, b[6:0]};
					length_known();
				end
			end
			ST_EXT0: begin
				plen = {b, 8'h00};
				st   = ST_EXT1;
			end
			ST_EXT1: begin
				plen[7:0] = b;
				length_known();
			end
			ST_KEY0, ST_KEY1, ST_KEY2: begin
				key = {key[23:0], b};
				st  = parse_st_t'(st + 4'd1);
			end
			ST_KEY3: begin
				key  = {key[23:0], b};
				pidx = 16'd0;
				if (plen != 16'd0)
					st = ST_DATA;
				else begin
					st = ST_HEAD0;
					if (is_msg && fin) begin
						tot       = int'(msg_total);
						msg_total = 16'd0;
						expect_result(KIND_EMPTY, 8'h00, CC_NORMAL, 1'b0, 1'b1,
							prefix_good(tot));
					end
				end
			end
			ST_DATA: begin
				d     = b ^ key[8 * (3 - pidx[1:0]) +: 8];
				lastb = (int'(pidx) + 1 >= int'(plen));
				if (is_msg) begin
					pos = int'(msg_total) + int'(pidx);
					if (pos == 0)
						prefix_val[7:0] = d;
					else if (pos == 1)
						prefix_val[15:8] = d;
				end
				pidx = pidx + 16'd1;
				if (!lastb) begin
					if (is_msg)
						expect_result(KIND_MSG, d, CC_NORMAL, 1'b0, 1'b0, 1'b0);
					else if (opcode == OP_PING)
						expect_result(KIND_PING, d, CC_NORMAL, 1'b0, 1'b0, 1'b0);
				end else begin
					st   = ST_HEAD0;
					pidx = 16'd0;
					if (is_msg) begin
						tot = int'(msg_total) + int'(plen);
						if (fin) begin
							msg_total = 16'd0;
							expect_result(KIND_MSG, d, CC_NORMAL, 1'b1, 1'b1, prefix_good(tot));
						end else begin
							msg_total = 16'(tot);
							expect_result(KIND_MSG, d, CC_NORMAL, 1'b1, 1'b0, 1'b0);
						end
					end else if (opcode == OP_PING)
						expect_result(KIND_PING, d, CC_NORMAL, 1'b1, 1'b0, 1'b0);
				end
			end
			default: st = ST_HEAD0;
		endcase
	endtask

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			st              = ST_HEAD0;
			closed          = 1'b0;
			fin             = 1'b0;
			rsv             = 3'd0;
			opcode          = OP_CONT;
			plen            = 16'd0;
			pidx            = 16'd0;
			key             = 32'd0;
			msg_total       = 16'd0;
			prefix_val      = 16'd0;
			fail_count      = 0;
			results_checked = 0;
			pending         = 0;
			expected_results.delete();
		end else begin
			if (data_valid && !data_stall)
				predict_byte(data_byte);
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: out_kind %0d out_byte 0x%02h",
						out_kind, out_byte);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("out_kind", want.kind, out_kind);
					check_field("out_byte", want.data, out_byte);
					check_field("close_code", want.code, close_code);
					check_field("frame_last", want.flast, frame_last);
					check_field("message_end", want.mend, message_end);
					check_field("prefix_ok", want.pok, prefix_ok);
					results_checked++;
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// ----- tb/sv/websocket_frame_deframer_tb.sv -----
// Top of the deframer testbench: clock, reset, framed byte stimulus and the
// result-side stall pattern; the verdict comes from the checker's counts.
// Depends on wsd_pkg, websocket_frame_deframer and the deframer checker.
`timescale 1ns / 100ps

module websocket_frame_deframer_tb;
	import wsd_pkg::*;

	typedef logic [7:0] byte_q_t[$];
	typedef enum int {
		END_UNMASKED, END_RSV, END_LEN64, END_TEXT,
		END_CLOSE, END_BIG_PING, END_BAD_OP, END_TOO_LONG
	} close_cause_t;

	localparam int RANDOM_BYTES = 1950;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       data_valid   = 1'b0;
	logic [7:0] data_byte    = 8'h00;
	logic       result_stall = 1'b0;
	logic       calm         = 1'b0;
	logic       data_stall;
	logic       result_valid;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic [1:0] close_code;
	logic       frame_last;
	logic       message_end;
	logic       prefix_ok;
	int         fail_count;
	int         pending;
	int         results_checked;

	int bytes_sent    = 0;
	int frames_sent   = 0;
	int messages_sent = 0;
	int pings_sent    = 0;
	int pongs_sent    = 0;
	int open_total    = 0;

	always #6 clk = ~clk;

	websocket_frame_deframer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data_byte    (data_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_kind     (out_kind),
		.out_byte     (out_byte),
		.close_code   (close_code),
		.frame_last   (frame_last),
		.message_end  (message_end),
		.prefix_ok    (prefix_ok)
	);

	websocket_frame_deframer_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.data_valid      (data_valid),
		.data_stall      (data_stall),
		.data_byte       (data_byte),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.out_kind        (out_kind),
		.out_byte        (out_byte),
		.close_code      (close_code),
		.frame_last      (frame_last),
		.message_end     (message_end),
		.prefix_ok       (prefix_ok),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	always @(posedge clk) begin
		result_stall <= !calm && ($urandom_range(0, 99) < 38);
	end

	task automatic push_byte(input logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < 38) begin
			data_valid <= 1'b0;
			@(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte  <= b;
		@(posedge clk);
		while (data_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic push_ext_length(input int n);
		push_byte({1'b1, LEN_EXT16});
		push_byte(n[15:8]);
		push_byte(n[7:0]);
	endtask

	task automatic send_frame(input logic fin, input logic [3:0] op, input byte_q_t body,
		input bit long_form, input logic [31:0] key);
		int n;
		n = body.size();
		push_byte({fin, 3'b000, op});
		if (long_form || n > 125)
			push_ext_length(n);
		else
			push_byte({1'b1, n[6:0]});
		for (int i = 0; i < 4; i++)
			push_byte(key[8 * (3 - i) +: 8]);
		for (int i = 0; i < n; i++)
			push_byte(body[i] ^ key[8 * (3 - (i % 4)) +: 8]);
		frames_sent++;
		if (op == OP_BIN || op == OP_CONT)
			open_total = fin ? 0 : open_total + n;
	endtask

	task automatic random_body(input int n, output byte_q_t body);
		body = {};
		repeat (n)
			body.push_back(8'($urandom));
	endtask

	task automatic send_control(input logic [3:0] op);
		byte_q_t body;
		int      n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 16);
		random_body(n, body);
		send_frame(1'($urandom), op, body, $urandom_range(0, 4) == 0, $urandom);
		if (op == OP_PING)
			pings_sent++;
		else
			pongs_sent++;
	endtask

	// One message split over up to four fragments, control frames in between.
	task automatic send_message(input int n);
		byte_q_t     body;
		byte_q_t     frag;
		int          nfrag;
		int          start;
		int          cut;
		logic [3:0]  op;
		logic [15:0] pfx;
		random_body(n, body);
		if (n >= PREFIX_BYTES && $urandom_range(0, 9) < 7) begin
			pfx     = 16'(n - PREFIX_BYTES);
			body[0] = pfx[7:0];
			body[1] = pfx[15:8];
		end
		nfrag = $urandom_range(1, 4);
		start = 0;
		for (int k = 0; k < nfrag; k++) begin
			cut  = (k == nfrag - 1) ? n - start : $urandom_range(0, n - start);
			frag = {};
			for (int i = 0; i < cut; i++)
				frag.push_back(body[start + i]);
			if (k == 0)
				op = ($urandom_range(0, 3) == 0) ? OP_CONT : OP_BIN;
			else
				op = ($urandom_range(0, 3) == 0) ? OP_BIN : OP_CONT;
			send_frame(k == nfrag - 1, op, frag, $urandom_range(0, 6) == 0, $urandom);
			start += cut;
			if (k != nfrag - 1 && $urandom_range(0, 4) == 0)
				send_control($urandom_range(0, 1) ? OP_PING : OP_PONG);
		end
		messages_sent++;
	endtask

	task automatic drain_results();
		data_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		byte_q_t      body;
		close_cause_t cause;
		int           pick;
		int           n;
		int           msg_no;
		logic [3:0]   op;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, one-byte message, two-byte message with a zero prefix
		// in extended length form, one-byte ping
		body = {};
		send_frame(1'b1, OP_BIN, body, 1'b0, 32'hFFFF_FFFF);
		body = {8'hFF};
		send_frame(1'b1, OP_BIN, body, 1'b0, 32'h0000_0000);
		body = {8'h00, 8'h00};
		send_frame(1'b1, OP_CONT, body, 1'b1, 32'hFFFF_FFFF);
		body = {8'hA5};
		send_frame(1'b0, OP_PING, body, 1'b0, $urandom);
		drain_results();

		msg_no = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			calm = (msg_no >= 30 && msg_no < 45);
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				pick = $urandom_range(0, 99);
				if (pick < 88)
					n = $urandom_range(0, 40);
				else if (pick < 98)
					n = $urandom_range(41, 300);
				else
					n = $urandom_range(301, 700);
				if (n > MAX_MESSAGE_BYTES - open_total)
					n = MAX_MESSAGE_BYTES - open_total;
				send_message(n);
				msg_no++;
			end else if (pick < 82)
				send_control(OP_PING);
			else if (pick < 90)
				send_control(OP_PONG);
			else begin
				// stray fragment: an unfinished message or a continuation with no start
				random_body($urandom_range(0, 12), body);
				op = $urandom_range(0, 1) ? OP_BIN : OP_CONT;
				send_frame(pick >= 95, (pick >= 95) ? OP_CONT : op, body,
					$urandom_range(0, 5) == 0, $urandom);
			end
			if ($urandom_range(0, 39) == 0)
				drain_results();
		end
		calm = 1'b0;

		cause = close_cause_t'($urandom_range(0, 7));
		case (cause)
			END_UNMASKED: begin
				push_byte({1'b1, 3'b000, OP_BIN});
				push_byte({1'b0, 7'($urandom)});
			end
			END_RSV: begin
				push_byte({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)});
				push_byte(8'($urandom));
			end
			END_LEN64: begin
				push_byte({1'b1, 3'b000, OP_BIN});
				push_byte({1'b1, LEN_EXT64});
			end
			END_TEXT: begin
				push_byte({1'($urandom), 3'b000, OP_TEXT});
				push_byte({1'b1, 7'($urandom_range(0, 125))});
			end
			END_CLOSE: begin
				push_byte({1'($urandom), 3'b000, OP_CLOSE});
				push_byte({1'b1, 7'($urandom_range(0, 125))});
			end
			END_BIG_PING: begin
				push_byte({1'b1, 3'b000, OP_PING});
				push_ext_length($urandom_range(126, 65535));
			end
			END_BAD_OP: begin
				op = $urandom_range(0, 1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
				push_byte({1'($urandom), 3'b000, op});
				push_byte({1'b1, 7'($urandom_range(0, 125))});
			end
			default: begin
				push_byte({1'($urandom), 3'b000, $urandom_range(0, 1) ? OP_BIN : OP_CONT});
				push_ext_length($urandom_range(MAX_MESSAGE_BYTES - open_total + 1, 65535));
			end
		endcase
		// the block is halted now; these beats must give nothing
		repeat (16)
			push_byte(8'($urandom));
		drain_results();
		repeat (8) @(posedge clk);

		$display("Covered %0d frames (%0d messages, %0d pings, %0d pongs),",
			frames_sent, messages_sent, pings_sent, pongs_sent);
		$display("%0d bytes in, %0d results checked.", bytes_sent, results_checked);
		$display("Stream ended on a %s close, then ignored bytes after the halt.", cause.name());
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#3_600_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/wsd_pkg.sv
rtl/wsd_parser.sv
rtl/wsd_queue.sv
rtl/websocket_frame_deframer.sv
tb/sv/websocket_frame_deframer_checker.sv
tb/sv/websocket_frame_deframer_tb.sv
